[rtl/core/texture_window_edge_address_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the texture window edge address block
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TEXTURE_WINDOW_EDGE_ADDRESS_MACROS_SVH
`define TEXTURE_WINDOW_EDGE_ADDRESS_MACROS_SVH

// Property checked on every rising edge outside reset.
`define TWEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define TWEA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/twea_pkg.sv]
// ---------------------------------------------------------------------------
// Texture window edge address package
// Widths, register indexes, edge modes and payload types of the block.
// ---------------------------------------------------------------------------
package twea_pkg;

  localparam int unsigned MaxDim   = 8192;
  localparam int unsigned SizeW    = 14;
  localparam int unsigned CoordW   = 13;
  localparam int unsigned SumW     = 14;
  localparam int unsigned BppW     = 5;
  localparam int unsigned PitchW   = 19;
  localparam int unsigned OffW     = 31;
  localparam int unsigned ProdW    = CoordW + PitchW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 19;

  // Remainder pipeline: two dividend bits are retired in each stage.
  localparam int unsigned RemBitsPerStage = 2;
  localparam int unsigned RemStages       = SumW / RemBitsPerStage;

  // Input stage, remainder stages, resolve, products, output register.
  localparam int unsigned NumStages = RemStages + 4;

  localparam logic [CfgIdxW-1:0] RegImageWidth    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWindowX       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWindowY       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEdgeMode      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBytesPerPixel = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSrcRowPitch   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDstRowPitch   = 3'd7;

  typedef enum logic [1:0] {
    EdgeZero   = 2'd0,
    EdgeClamp  = 2'd1,
    EdgeMirror = 2'd2,
    EdgeRepeat = 2'd3
  } edge_mode_e;

  typedef struct packed {
    logic [SizeW-1:0]  eff_w;
    logic [SizeW-1:0]  eff_h;
    logic [SizeW-1:0]  div_w;
    logic [SizeW-1:0]  div_h;
    logic [CoordW-1:0] win_x;
    logic [CoordW-1:0] win_y;
    edge_mode_e        mode;
    logic [BppW-1:0]   bpp;
    logic [PitchW-1:0] src_pitch;
    logic [PitchW-1:0] dst_pitch;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] out_row;
    logic [CoordW-1:0] out_col;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0] source_row;
    logic [CoordW-1:0] source_col;
    logic              fill_zero;
    logic [OffW-1:0]   source_offset;
    logic [OffW-1:0]   dest_offset;
  } out_t;

  function automatic logic [SizeW-1:0] eff_size(logic [SizeW-1:0] s);
    if (s < SizeW'(2)) begin
      return SizeW'(2);
    end
    if (s > SizeW'(MaxDim)) begin
      return SizeW'(MaxDim);
    end
    return s;
  endfunction

endpackage

[rtl/core/texture_window_edge_address.sv]
// ---------------------------------------------------------------------------
// Texture window edge address generator
// Maps a destination pixel of a copy window to its source pixel and offsets.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o   in_t  (out_row, out_col)
//   out      output     out_valid_o / out_stall_i out_t (source/dest offsets)
//   cfg      input      cfg_valid_i / cfg_ready_o index and write data
//
// One item enters per cycle unless the pipeline holds; most of the stages
// on the way to a valid output are the seven-stage remainder pipeline.
// The whole pipeline advances together; it holds only while a valid result
// waits at the output and the sink stalls, which also stalls the input.
// Reset clears all valid bits and loads the register defaults.
// Configuration takes effect immediately; the user must write it only while idle (not enforced).
//
// The window origin is added in the input stage.  Each axis coordinate
// then runs through a remainder pipeline against either the image size
// (repeat) or the mirror period 2*size-2.  The resolve stage picks the
// edge-mode result, and the final two stages form the byte offsets with
// registered products followed by one add.
module texture_window_edge_address import twea_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg;
  logic              en;
  logic              valid_q [NumStages];
  logic [SumW-1:0]   c_row_q, c_col_q;
  logic [CoordW-1:0] orow_q, ocol_q;
  logic [SumW-1:0]   c_row_dly_q [RemStages];
  logic [SumW-1:0]   c_col_dly_q [RemStages];
  logic [CoordW-1:0] orow_dly_q  [RemStages];
  logic [CoordW-1:0] ocol_dly_q  [RemStages];
  logic [SizeW-1:0]  rem_row, rem_col;
  out_t              res;
  out_t              out_q;

  twea_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // Every stage moves unless a finished result is held by the sink.
  assign en         = !(valid_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStages; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int s = 1; s < NumStages; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // Input stage: the window origin shifts the coordinate into image space.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_row_q <= SumW'(cfg.win_y) + SumW'(in_data_i.out_row);
      c_col_q <= SumW'(cfg.win_x) + SumW'(in_data_i.out_col);
      orow_q  <= in_data_i.out_row;
      ocol_q  <= in_data_i.out_col;
    end
  end

  twea_rem u_rem_row (
    .clk_i,
    .en_i       (en),
    .dividend_i (c_row_q),
    .divisor_i  (cfg.div_h),
    .rem_o      (rem_row)
  );

  twea_rem u_rem_col (
    .clk_i,
    .en_i       (en),
    .dividend_i (c_col_q),
    .divisor_i  (cfg.div_w),
    .rem_o      (rem_col)
  );

  // Side data travels alongside the remainder stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_row_dly_q[0] <= c_row_q;
      c_col_dly_q[0] <= c_col_q;
      orow_dly_q[0]  <= orow_q;
      ocol_dly_q[0]  <= ocol_q;
      for (int s = 1; s < RemStages; s++) begin
        c_row_dly_q[s] <= c_row_dly_q[s-1];
        c_col_dly_q[s] <= c_col_dly_q[s-1];
        orow_dly_q[s]  <= orow_dly_q[s-1];
        ocol_dly_q[s]  <= ocol_dly_q[s-1];
      end
    end
  end

  twea_addr u_addr (
    .clk_i,
    .en_i      (en),
    .cfg_i     (cfg),
    .c_row_i   (c_row_dly_q[RemStages-1]),
    .c_col_i   (c_col_dly_q[RemStages-1]),
    .rem_row_i (rem_row),
    .rem_col_i (rem_col),
    .out_row_i (orow_dly_q[RemStages-1]),
    .out_col_i (ocol_dly_q[RemStages-1]),
    .res_o     (res)
  );

  // Output register: the result stays put while the sink stalls.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = out_q;

endmodule

[rtl/core/twea_cfg.sv]
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the register file and derives effective sizes and modulus divisors.
// ---------------------------------------------------------------------------
module twea_cfg import twea_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [SizeW-1:0]  width_q, height_q;
  logic [CoordW-1:0] win_x_q, win_y_q;
  edge_mode_e        mode_q;
  logic [BppW-1:0]   bpp_q;
  logic [PitchW-1:0] src_pitch_q, dst_pitch_q;
  logic [SizeW:0]    period_w, period_h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= SizeW'(2);
      height_q    <= SizeW'(2);
      win_x_q     <= '0;
      win_y_q     <= '0;
      mode_q      <= EdgeZero;
      bpp_q       <= BppW'(4);
      src_pitch_q <= PitchW'(256);
      dst_pitch_q <= PitchW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegImageWidth:    width_q     <= cfg_data_i[SizeW-1:0];
        RegImageHeight:   height_q    <= cfg_data_i[SizeW-1:0];
        RegWindowX:       win_x_q     <= cfg_data_i[CoordW-1:0];
        RegWindowY:       win_y_q     <= cfg_data_i[CoordW-1:0];
        RegEdgeMode:      mode_q      <= edge_mode_e'(cfg_data_i[1:0]);
        RegBytesPerPixel: bpp_q       <= cfg_data_i[BppW-1:0];
        RegSrcRowPitch:   src_pitch_q <= cfg_data_i[PitchW-1:0];
        RegDstRowPitch:   dst_pitch_q <= cfg_data_i[PitchW-1:0];
        default: ;
      endcase
    end
  end

  // Mirror mode reduces modulo the period 2*size-2, the others modulo size.
  always_comb begin
    cfg_o           = '0;
    cfg_o.eff_w     = eff_size(width_q);
    cfg_o.eff_h     = eff_size(height_q);
    period_w        = {cfg_o.eff_w, 1'b0} - (SizeW+1)'(2);
    period_h        = {cfg_o.eff_h, 1'b0} - (SizeW+1)'(2);
    cfg_o.div_w     = (mode_q == EdgeMirror) ? period_w[SizeW-1:0] : cfg_o.eff_w;
    cfg_o.div_h     = (mode_q == EdgeMirror) ? period_h[SizeW-1:0] : cfg_o.eff_h;
    cfg_o.win_x     = win_x_q;
    cfg_o.win_y     = win_y_q;
    cfg_o.mode      = mode_q;
    cfg_o.bpp       = bpp_q;
    cfg_o.src_pitch = src_pitch_q;
    cfg_o.dst_pitch = dst_pitch_q;
  end

endmodule

[rtl/core/twea_rem.sv]
// ---------------------------------------------------------------------------
// Pipelined remainder unit
// Restoring remainder, a fixed number of dividend bits retired per stage.
// ---------------------------------------------------------------------------
module twea_rem import twea_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SumW-1:0]  dividend_i,
  input  logic [SizeW-1:0] divisor_i,
  output logic [SizeW-1:0] rem_o
);

  logic [SumW-1:0]  num_q [RemStages];
  logic [SizeW-1:0] rem_q [RemStages];
  logic [SumW-1:0]  num_d [RemStages];
  logic [SizeW-1:0] rem_d [RemStages];

  function automatic logic [SizeW-1:0] rem_step(logic [SizeW-1:0] r, logic b,
                                                logic [SizeW-1:0] d);
    logic [SizeW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SizeW-1:0];
  endfunction

  // The dividend shifts left as its upper bits are consumed.
  always_comb begin
    logic [SumW-1:0]  num;
    logic [SizeW-1:0] r;
    for (int s = 0; s < RemStages; s++) begin
      num = (s == 0) ? dividend_i : num_q[(s == 0) ? 0 : s-1];
      r   = (s == 0) ? '0 : rem_q[(s == 0) ? 0 : s-1];
      for (int k = 0; k < RemBitsPerStage; k++) begin
        r   = rem_step(r, num[SumW-1], divisor_i);
        num = {num[SumW-2:0], 1'b0};
      end
      num_d[s] = num;
      rem_d[s] = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < RemStages; s++) begin
        num_q[s] <= num_d[s];
        rem_q[s] <= rem_d[s];
      end
    end
  end

  assign rem_o = rem_q[RemStages-1];

endmodule

[rtl/core/twea_addr.sv]
// ---------------------------------------------------------------------------
// Edge resolve and offset arithmetic
// Applies the edge mode, then forms source and destination byte offsets.
// ---------------------------------------------------------------------------
module twea_addr import twea_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  input  logic [SumW-1:0]   c_row_i,
  input  logic [SumW-1:0]   c_col_i,
  input  logic [SizeW-1:0]  rem_row_i,
  input  logic [SizeW-1:0]  rem_col_i,
  input  logic [CoordW-1:0] out_row_i,
  input  logic [CoordW-1:0] out_col_i,
  output out_t              res_o
);

  logic [CoordW-1:0] srow_d, scol_d;
  logic              fill_d;
  logic [CoordW-1:0] srow_q, scol_q, orow_q, ocol_q;
  logic              fill_q;
  logic [CoordW-1:0] srow2_q, scol2_q;
  logic              fill2_q;
  logic [ProdW-1:0]  sp_row_q, dp_row_q;
  logic [ProdW-1:0]  sp_col_q, dp_col_q;
  logic              row_ok, col_ok;
  logic [SizeW-1:0]  row_res, col_res;
  logic [ProdW-1:0]  src_sum, dst_sum;

  function automatic logic [SizeW:0] resolve(logic [SumW-1:0] c, logic [SizeW-1:0] n,
                                             logic [SizeW-1:0] d, logic [SizeW-1:0] m,
                                             edge_mode_e mode);
    logic [SizeW-1:0] v;
    logic             ok;
    v  = c[SizeW-1:0];
    ok = 1'b1;
    if (c >= n) begin
      case (mode)
        EdgeZero: begin
          v  = '0;
          ok = 1'b0;
        end
        EdgeClamp:  v = n - SizeW'(1);
        EdgeMirror: v = (m < n) ? m : d - m;
        default:    v = m;
      endcase
    end
    return {ok, v};
  endfunction

  always_comb begin
    {row_ok, row_res} = resolve(c_row_i, cfg_i.eff_h, cfg_i.div_h, rem_row_i, cfg_i.mode);
    {col_ok, col_res} = resolve(c_col_i, cfg_i.eff_w, cfg_i.div_w, rem_col_i, cfg_i.mode);
    fill_d = !(row_ok && col_ok);
    srow_d = fill_d ? '0 : row_res[CoordW-1:0];
    scol_d = fill_d ? '0 : col_res[CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srow_q   <= srow_d;
      scol_q   <= scol_d;
      fill_q   <= fill_d;
      orow_q   <= out_row_i;
      ocol_q   <= out_col_i;
      srow2_q  <= srow_q;
      scol2_q  <= scol_q;
      fill2_q  <= fill_q;
      sp_row_q <= ProdW'(srow_q * cfg_i.src_pitch);
      sp_col_q <= ProdW'(scol_q * cfg_i.bpp);
      dp_row_q <= ProdW'(orow_q * cfg_i.dst_pitch);
      dp_col_q <= ProdW'(ocol_q * cfg_i.bpp);
    end
  end

  assign src_sum = sp_row_q + sp_col_q;
  assign dst_sum = dp_row_q + dp_col_q;

  always_comb begin
    res_o               = '0;
    res_o.source_row    = srow2_q;
    res_o.source_col    = scol2_q;
    res_o.fill_zero     = fill2_q;
    res_o.source_offset = src_sum[OffW-1:0];
    res_o.dest_offset   = dst_sum[OffW-1:0];
  end

endmodule

[rtl/core/twea_chk.sv]
// ---------------------------------------------------------------------------
// Port checker for the texture window edge address block
// Watches the top-level ports and is bound to every instance of it.
// ---------------------------------------------------------------------------
`include "texture_window_edge_address_macros.svh"

module twea_chk import twea_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input in_t                 in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_t                out_data_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  `TWEA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `TWEA_ASSERT(a_fill_clean, out_valid_o && out_data_o.fill_zero |-> out_data_o.source_row == '0 && out_data_o.source_col == '0 && out_data_o.source_offset == '0, "zero-filled result carries a source address")
  `TWEA_ASSERT(a_stall_link, in_stall_o == (out_valid_o && out_stall_i), "input stall not tied to a held result")
  `TWEA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind texture_window_edge_address twea_chk u_twea_chk (.*);

[sim/tb_texture_window_edge_address.sv]
// ---------------------------------------------------------------------------
// Testbench for the texture window edge address generator
// Drives destination coordinates under several register settings, predicts
// the source and destination addresses and compares each output transfer.
// ---------------------------------------------------------------------------
module tb_texture_window_edge_address;
  timeunit 1ns;
  timeprecision 1ps;

  import twea_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned WatchdogLimit = 20000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  texture_window_edge_address dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the block's registers, kept at their raw widths.
  logic [13:0]  img_w, img_h;
  logic [12:0]  win_x, win_y;
  edge_mode_e   mode;
  logic [4:0]   bpp;
  logic [18:0]  src_pitch, dst_pitch;

  out_t   pending_addr_q[$];
  int     errors;
  int     idle_pct;
  bit     stall_enable;
  int     quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Effective image size: at least two and at most the largest dimension.
  function automatic longint unsigned clip_size(logic [13:0] s);
    if (s < 2) return 2;
    if (s > MaxDim) return MaxDim;
    return 64'(s);
  endfunction

  // Resolves one axis coordinate against the image size. Returns 0 when the
  // pixel falls into zero fill.
  function automatic bit map_axis(longint unsigned c, longint unsigned n,
                                  output longint unsigned res);
    longint unsigned period, m;
    res = 0;
    if (c < n) begin
      res = c;
      return 1;
    end
    case (mode)
      EdgeZero: begin
        return 0;
      end
      EdgeClamp: begin
        res = n - 1;
      end
      EdgeMirror: begin
        period = 2 * n - 2;
        m = c % period;
        res = (m < n) ? m : period - m;
      end
      default: begin
        res = c % n;
      end
    endcase
    return 1;
  endfunction

  function automatic out_t predict_address(in_t item);
    out_t r;
    longint unsigned srow, scol, soff, doff;
    bit row_ok, col_ok;
    row_ok = map_axis(longint'(win_y) + item.out_row, clip_size(img_h), srow);
    col_ok = map_axis(longint'(win_x) + item.out_col, clip_size(img_w), scol);
    soff = 0;
    if (!(row_ok && col_ok)) begin
      srow = 0;
      scol = 0;
    end else begin
      soff = srow * src_pitch + scol * bpp;
    end
    doff = longint'(item.out_row) * dst_pitch + longint'(item.out_col) * bpp;
    r.source_row    = srow[12:0];
    r.source_col    = scol[12:0];
    r.fill_zero     = !(row_ok && col_ok);
    r.source_offset = soff[30:0];
    r.dest_offset   = doff[30:0];
    return r;
  endfunction

  // Output side: random stall, then compare every output transfer with the
  // oldest predicted address.
  always @(negedge clk_i) begin
    if (stall_enable) begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_addr_q.size() == 0) begin
        $display("%0t: unexpected output %p", $time, out_data_o);
        errors++;
      end else begin
        out_t exp_r;
        exp_r = pending_addr_q.pop_front();
        if (exp_r.source_row !== out_data_o.source_row) begin
          $display("%0t: source_row expected %0d actual %0d", $time,
                   exp_r.source_row, out_data_o.source_row);
          errors++;
        end
        if (exp_r.source_col !== out_data_o.source_col) begin
          $display("%0t: source_col expected %0d actual %0d", $time,
                   exp_r.source_col, out_data_o.source_col);
          errors++;
        end
        if (exp_r.fill_zero !== out_data_o.fill_zero) begin
          $display("%0t: fill_zero expected %0d actual %0d", $time,
                   exp_r.fill_zero, out_data_o.fill_zero);
          errors++;
        end
        if (exp_r.source_offset !== out_data_o.source_offset) begin
          $display("%0t: source_offset expected %0d actual %0d", $time,
                   exp_r.source_offset, out_data_o.source_offset);
          errors++;
        end
        if (exp_r.dest_offset !== out_data_o.dest_offset) begin
          $display("%0t: dest_offset expected %0d actual %0d", $time,
                   exp_r.dest_offset, out_data_o.dest_offset);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Sends one coordinate. The valid stays high into the next item when no
  // gap is drawn, so back-to-back transfers happen.
  task automatic send_coord(logic [12:0] row, logic [12:0] col);
    in_t item;
    item.out_row = row;
    item.out_col = col;
    while (stall_enable && ($urandom_range(99) < idle_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_addr_q = {pending_addr_q, predict_address(item)};
    @(negedge clk_i);
  endtask

  // Waits until every predicted address has come out, then lets the
  // pipeline settle before the next register write.
  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending_addr_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One register transfer, after which the channel is left idle before returning.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegImageWidth:    img_w = val[13:0];
      RegImageHeight:   img_h = val[13:0];
      RegWindowX:       win_x = val[12:0];
      RegWindowY:       win_y = val[12:0];
      RegEdgeMode:      mode = edge_mode_e'(val[1:0]);
      RegBytesPerPixel: bpp = val[4:0];
      RegSrcRowPitch:   src_pitch = val;
      default:          dst_pitch = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_all(logic [13:0] w, logic [13:0] h, logic [12:0] x,
                         logic [12:0] y, edge_mode_e m, logic [4:0] b,
                         logic [18:0] sp, logic [18:0] dp);
    drain_all();
    write_reg(RegImageWidth, CfgDataW'(w));
    write_reg(RegImageHeight, CfgDataW'(h));
    write_reg(RegWindowX, CfgDataW'(x));
    write_reg(RegWindowY, CfgDataW'(y));
    write_reg(RegEdgeMode, CfgDataW'(m));
    write_reg(RegBytesPerPixel, CfgDataW'(b));
    write_reg(RegSrcRowPitch, sp);
    write_reg(RegDstRowPitch, dp);
  endtask

  // Field extremes and every edge mode on a small image, including a window
  // origin beyond the image and sizes below two and above the maximum.
  task automatic test_directed();
    edge_mode_e m;
    m = EdgeZero;
    set_all(14'd5, 14'd4, 13'd0, 13'd0, EdgeZero, 5'd4, 19'd256, 19'd256);
    send_coord(13'd0, 13'd0);
    send_coord(13'd8191, 13'd8191);
    send_coord(13'd3, 13'd4);
    send_coord(13'd4, 13'd2);
    for (int k = 1; k < 4; k++) begin
      m = edge_mode_e'(2'(k));
      set_all(14'd5, 14'd4, 13'd2, 13'd1, m, 5'd16, 19'd262144, 19'd1);
      send_coord(13'd0, 13'd0);
      send_coord(13'd8191, 13'd8191);
      send_coord(13'd5, 13'd7);
      send_coord(13'd2, 13'd2);
    end
    // Sizes outside the legal range and a window origin past the image.
    set_all(14'd0, 14'd16383, 13'd8191, 13'd8191, EdgeMirror, 5'd31,
            19'h7FFFF, 19'h7FFFF);
    send_coord(13'd0, 13'd0);
    send_coord(13'd8191, 13'd8191);
    send_coord(13'd1234, 13'd17);
    set_all(14'd1, 14'd8192, 13'd1, 13'd0, EdgeRepeat, 5'd0, 19'd0, 19'd0);
    send_coord(13'd8191, 13'd1);
    send_coord(13'd4097, 13'd0);
  endtask

  // One random phase with random registers, mostly legal and near the
  // image edges so that every mode is exercised.
  task automatic test_random_phase(int count);
    logic [13:0] w, h;
    logic [12:0] row, col;
    if ($urandom_range(3) == 0) begin
      w = 14'($urandom);
      h = 14'($urandom);
    end else begin
      w = 14'($urandom_range(2, ($urandom_range(1) != 0) ? 40 : 8192));
      h = 14'($urandom_range(2, ($urandom_range(1) != 0) ? 40 : 8192));
    end
    set_all(w, h, 13'($urandom), 13'($urandom),
            edge_mode_e'(2'($urandom_range(3))), 5'($urandom),
            19'($urandom), 19'($urandom));
    if ($urandom_range(1) != 0) begin
      write_reg(RegWindowX, CfgDataW'($urandom_range(0, 60)));
      write_reg(RegWindowY, CfgDataW'($urandom_range(0, 60)));
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(2) == 0) begin
        row = 13'($urandom);
        col = 13'($urandom);
      end else begin
        row = 13'($urandom_range(0, 32'(2 * clip_size(h) + 4)));
        col = 13'($urandom_range(0, 32'(2 * clip_size(w) + 4)));
      end
      send_coord(row, col);
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 24; p++) begin
      // One phase runs without any idling on either side.
      stall_enable = (p != 5);
      test_random_phase(70);
      // Sender waits for every result before resuming.
      if (p == 10) begin
        drain_all();
      end
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    errors       = 0;
    idle_pct     = 16;
    stall_enable = 1'b1;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    img_w = 14'd2;
    img_h = 14'd2;
    win_x = '0;
    win_y = '0;
    mode  = EdgeZero;
    bpp   = 5'd4;
    src_pitch = 19'd256;
    dst_pitch = 19'd256;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset defaults first, before any register is touched.
    send_coord(13'd1, 13'd1);
    send_coord(13'd2, 13'd0);
    test_directed();
    test_random();
    drain_all();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
